// ===== rtl/bvl_pkg.sv =====
// Package for the bounded value list: capacity, widths, command and status
// codes, the memory request and response structs, and the slot arithmetic.
// Used by every module of the block; depends on nothing.
package bvl_pkg;

    // Capacity of the list and the widths that follow from it.
    localparam int CAPACITY = 256;
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int SUM_W    = SLOT_W + 1;
    localparam int DATA_W   = 32;

    // Command codes.
    localparam logic [2:0] CMD_CLEAR    = 3'd0;
    localparam logic [2:0] CMD_APPEND   = 3'd1;
    localparam logic [2:0] CMD_PREPEND  = 3'd2;
    localparam logic [2:0] CMD_REMOVE   = 3'd3;
    localparam logic [2:0] CMD_CONTAINS = 3'd4;

    // Status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    // One write port and one read port into the entry memory.
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [SLOT_W-1:0] raddr;
    } mem_req_t;

    // Finished result from the sequencer.
    typedef struct packed {
        logic               done;
        logic [1:0]         status;
        logic               found;
        logic [COUNT_W-1:0] count;
    } rsp_t;

    // Physical slot of a list position: (base + offset) modulo CAPACITY.
    // The sum stays below twice the capacity, so one subtract is enough.
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                   input logic [COUNT_W-1:0] offset);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(offset);
        if (sum >= SUM_W'(CAPACITY)) begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[SLOT_W-1:0];
    endfunction

endpackage

// ===== rtl/bvl_mem.sv =====
// Entry memory of the bounded value list: one write port, one read port,
// registered read data. Depends on bvl_pkg for widths and the request struct.
module bvl_mem (
    input  logic                        aclk,
    input  bvl_pkg::mem_req_t           req,
    output logic [bvl_pkg::DATA_W-1:0]  rd_data
);

    logic [bvl_pkg::DATA_W-1:0] mem_reg [bvl_pkg::CAPACITY];
    logic [bvl_pkg::DATA_W-1:0] rd_data_reg;

    // Write and registered read. Entries are undefined until written.
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem_reg[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem_reg[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/bvl_ctrl.sv =====
// Command sequencer of the bounded value list. It keeps head and count,
// scans the memory one entry per cycle through a single shared comparator,
// and closes the gap after a remove. Depends on bvl_pkg.
module bvl_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    in_cmd,
    input  logic [bvl_pkg::DATA_W-1:0]    in_value,
    input  logic [bvl_pkg::DATA_W-1:0]    rd_data,
    output bvl_pkg::mem_req_t             mem_req,
    input  logic                          out_free,
    output bvl_pkg::rsp_t                 rsp
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                    state_reg,  state_next;
    logic [2:0]                    cmd_reg,    cmd_next;
    logic [bvl_pkg::DATA_W-1:0]    value_reg,  value_next;
    logic [bvl_pkg::SLOT_W-1:0]    head_reg,   head_next;
    logic [bvl_pkg::COUNT_W-1:0]   fill_reg,   fill_next;
    logic [bvl_pkg::COUNT_W-1:0]   idx_reg,    idx_next;
    logic [bvl_pkg::COUNT_W-1:0]   pidx_reg,   pidx_next;
    logic                          pend_reg,   pend_next;
    logic [1:0]                    status_reg, status_next;
    logic                          found_reg,  found_next;
    logic                          hit;
    logic                          full;
    logic [bvl_pkg::SLOT_W-1:0]    head_dec;

    // The comparator sees the entry read in the previous cycle.
    assign hit  = pend_reg && (rd_data == value_reg);
    assign full = (fill_reg == bvl_pkg::COUNT_W'(bvl_pkg::CAPACITY));
    assign head_dec = (head_reg == '0) ? bvl_pkg::SLOT_W'(bvl_pkg::CAPACITY - 1)
                                       : head_reg - bvl_pkg::SLOT_W'(1);

    assign in_ready = (state_reg == ST_IDLE);

    // Sequencer next-state logic.
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        value_next    = value_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        pidx_next     = pidx_reg;
        pend_next     = pend_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = bvl_pkg::slot_add(head_reg, pidx_reg);
        mem_req.wdata = rd_data;
        mem_req.raddr = bvl_pkg::slot_add(head_reg, idx_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd_next    = in_cmd;
                    value_next  = in_value;
                    status_next = bvl_pkg::STATUS_OK;
                    found_next  = 1'b0;
                    state_next  = ST_DONE;
                    unique case (in_cmd)
                        bvl_pkg::CMD_CLEAR: begin
                            fill_next = '0;
                            head_next = '0;
                        end
                        bvl_pkg::CMD_APPEND: begin
                            if (full) begin
                                status_next = bvl_pkg::STATUS_FULL;
                            end else begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = bvl_pkg::slot_add(head_reg, fill_reg);
                                mem_req.wdata = in_value;
                                fill_next     = fill_reg + bvl_pkg::COUNT_W'(1);
                            end
                        end
                        bvl_pkg::CMD_PREPEND: begin
                            if (full) begin
                                status_next = bvl_pkg::STATUS_FULL;
                            end else begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = head_dec;
                                mem_req.wdata = in_value;
                                head_next     = head_dec;
                                fill_next     = fill_reg + bvl_pkg::COUNT_W'(1);
                            end
                        end
                        bvl_pkg::CMD_REMOVE, bvl_pkg::CMD_CONTAINS: begin
                            idx_next   = '0;
                            pend_next  = 1'b0;
                            state_next = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Issue one read per cycle; compare each entry in the cycle after its read.
            ST_SCAN: begin
                if (hit) begin
                    if (cmd_reg == bvl_pkg::CMD_CONTAINS) begin
                        found_next = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        idx_next   = pidx_reg + bvl_pkg::COUNT_W'(1);
                        pend_next  = 1'b0;
                        state_next = ST_SHIFT;
                    end
                end else if (idx_reg == fill_reg) begin
                    if (cmd_reg == bvl_pkg::CMD_REMOVE) begin
                        status_next = bvl_pkg::STATUS_NOT_FOUND;
                    end
                    pend_next  = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                    idx_next  = idx_reg + bvl_pkg::COUNT_W'(1);
                end
            end

            // Move each later entry down one position; the write trails the read.
            ST_SHIFT: begin
                if (pend_reg) begin
                    mem_req.we = 1'b1;
                    pidx_next  = pidx_reg + bvl_pkg::COUNT_W'(1);
                end
                if (idx_reg != fill_reg) begin
                    pend_next = 1'b1;
                    idx_next  = idx_reg + bvl_pkg::COUNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        fill_next  = fill_reg - bvl_pkg::COUNT_W'(1);
                        state_next = ST_DONE;
                    end
                end
            end

            // Hand the result over once the output register can take it.
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.done   = (state_reg == ST_DONE);
    assign rsp.status = status_reg;
    assign rsp.found  = found_reg;
    assign rsp.count  = fill_reg;

    // Control state is reset; the command and data registers need none.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        value_reg  <= value_next;
        idx_reg    <= idx_next;
        pidx_reg   <= pidx_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

    // The count never passes the capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= bvl_pkg::COUNT_W'(bvl_pkg::CAPACITY))
        else $error("bvl_ctrl: count above capacity");

    // The head slot always names a real slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        bvl_pkg::SUM_W'(head_reg) < bvl_pkg::SUM_W'(bvl_pkg::CAPACITY))
        else $error("bvl_ctrl: head slot out of range");

    // The memory is written only on an add or while closing a gap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.we |-> (state_reg == ST_IDLE || state_reg == ST_SHIFT))
        else $error("bvl_ctrl: memory write outside add or shift");

    // The read position never runs past the list.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_SHIFT) |-> idx_reg <= fill_reg)
        else $error("bvl_ctrl: read position past the end");

    // A result that is handed over returns the sequencer to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (rsp.done && out_free) |=> state_reg == ST_IDLE)
        else $error("bvl_ctrl: sequencer did not return to idle");

endmodule

// ===== rtl/bounded_value_list_core.sv =====
// Top level of the bounded value list: command sequencer, entry memory and
// the result register. Depends on bvl_pkg, bvl_ctrl and bvl_mem.
//
// The block keeps an ordered list of up to 256 signed 32-bit values and takes
// one command per input beat: clear, append, prepend, remove first match or
// contains. Each command gives exactly one result beat with a status, a found
// flag and the count after the command. Clear, append, prepend and unknown
// commands go from acceptance straight to the result state. Contains and
// remove scan the list first, so they take longer as the list grows: the
// single read port of the entry memory delivers one entry per cycle to the
// one comparator and, after a match, to the gap-closing copy. The block
// takes one command at a time; the result register lets the next command be
// accepted while a result still waits on the output. The memory needs no
// clearing pass after reset, so the first command is taken right away.
module bounded_value_list_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_cmd,
    input  logic signed [bvl_pkg::DATA_W-1:0]  s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_status,
    output logic                               m_found,
    output logic [bvl_pkg::COUNT_W-1:0]        m_count
);

    bvl_pkg::mem_req_t           mem_req;
    bvl_pkg::rsp_t               rsp;
    logic [bvl_pkg::DATA_W-1:0]  rd_data;
    logic                        out_free;

    logic                        m_valid_reg,  m_valid_next;
    logic [1:0]                  m_status_reg;
    logic                        m_found_reg;
    logic [bvl_pkg::COUNT_W-1:0] m_count_reg;

    bvl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_cmd   (s_cmd),
        .in_value ($unsigned(s_value)),
        .rd_data  (rd_data),
        .mem_req  (mem_req),
        .out_free (out_free),
        .rsp      (rsp)
    );

    bvl_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // The result register is free when empty or when its beat leaves now.
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (rsp.done && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload is loaded together with the valid flag.
    always_ff @(posedge aclk) begin
        if (rsp.done && out_free) begin
            m_status_reg <= rsp.status;
            m_found_reg  <= rsp.found;
            m_count_reg  <= rsp.count;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_found  = m_found_reg;
    assign m_count  = m_count_reg;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bounded_value_list_core: random command beats
// checked against a shadow copy of the list. Depends on bvl_pkg and the core.
module tb;

    localparam int RANDOM_ITEMS = 1700;
    localparam int LIMIT_CYCLES = 3000000;
    localparam int PRESSURE_AT  = 300;
    localparam int PRESSURE_LEN = 400;

    // One result beat as the list should report it.
    typedef struct {
        logic [1:0]                  status;
        logic                        found;
        logic [bvl_pkg::COUNT_W-1:0] count;
    } list_result_t;

    // Shadow copy of the list. Each accepted command updates it and queues the
    // result that the block must return for that command.
    class list_shadow;
        logic [bvl_pkg::DATA_W-1:0] slots [bvl_pkg::CAPACITY];
        int unsigned                head;
        int unsigned                fill;
        list_result_t               pending_results[$];
        int                         errors;
        int                         accepted;

        function new();
            head     = 0;
            fill     = 0;
            errors   = 0;
            accepted = 0;
        endfunction

        function int unsigned slot_of(int unsigned pos);
            return (head + pos) % bvl_pkg::CAPACITY;
        endfunction

        function logic [bvl_pkg::DATA_W-1:0] value_at(int unsigned pos);
            return slots[slot_of(pos)];
        endfunction

        // Position of the first entry, from the head, that equals v.
        function bit find_first(logic [bvl_pkg::DATA_W-1:0] v, output int unsigned pos);
            pos = 0;
            for (int unsigned i = 0; i < fill; i++) begin
                if (slots[slot_of(i)] === v) begin
                    pos = i;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void take_command(logic [2:0] c, logic [bvl_pkg::DATA_W-1:0] v);
            list_result_t r;
            int unsigned  pos;
            r.status = bvl_pkg::STATUS_OK;
            r.found  = 1'b0;
            accepted++;
            case (c)
                bvl_pkg::CMD_CLEAR: begin
                    fill = 0;
                    head = 0;
                end
                bvl_pkg::CMD_APPEND: begin
                    if (fill >= bvl_pkg::CAPACITY) begin
                        r.status = bvl_pkg::STATUS_FULL;
                    end else begin
                        slots[slot_of(fill)] = v;
                        fill++;
                    end
                end
                bvl_pkg::CMD_PREPEND: begin
                    if (fill >= bvl_pkg::CAPACITY) begin
                        r.status = bvl_pkg::STATUS_FULL;
                    end else begin
                        head = (head + bvl_pkg::CAPACITY - 1) % bvl_pkg::CAPACITY;
                        slots[head] = v;
                        fill++;
                    end
                end
                bvl_pkg::CMD_REMOVE: begin
                    // Later entries slide down one position to close the gap.
                    if (find_first(v, pos)) begin
                        for (int unsigned i = pos; i + 1 < fill; i++) begin
                            slots[slot_of(i)] = slots[slot_of(i + 1)];
                        end
                        fill--;
                    end else begin
                        r.status = bvl_pkg::STATUS_NOT_FOUND;
                    end
                end
                bvl_pkg::CMD_CONTAINS: begin
                    r.found = find_first(v, pos);
                end
                default: begin
                end
            endcase
            r.count = bvl_pkg::COUNT_W'(fill);
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [1:0] status, logic found,
                          logic [bvl_pkg::COUNT_W-1:0] count);
            list_result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with no command waiting for it");
            end else begin
                want = pending_results.pop_front();
                if (status !== want.status) begin
                    report_mismatch($sformatf("status got %0d want %0d", status, want.status));
                end
                if (found !== want.found) begin
                    report_mismatch($sformatf("found got %0b want %0b", found, want.found));
                end
                if (count !== want.count) begin
                    report_mismatch($sformatf("count got %0d want %0d", count, want.count));
                end
            end
        endtask
    endclass

    logic                               aclk;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic [2:0]                         s_cmd;
    logic signed [bvl_pkg::DATA_W-1:0]  s_value;
    logic                               m_valid;
    logic                               m_ready;
    logic [1:0]                         m_status;
    logic                               m_found;
    logic [bvl_pkg::COUNT_W-1:0]        m_count;

    list_shadow sb;
    int         cycle_count;
    int         items_sent;
    bit         sender_idles;
    bit         pressure_done;

    bounded_value_list_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_cmd    (s_cmd),
        .s_value  (s_value),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status),
        .m_found  (m_found),
        .m_count  (m_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(15, 50);
    endfunction

    // Values come mostly from a small pool so that searches hit often.
    function automatic logic [bvl_pkg::DATA_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 3) begin
            return $urandom;
        end
        case ($urandom_range(0, 11))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h0000_0001;
            5:       return 32'h0000_0002;
            6:       return 32'h5555_5555;
            7:       return 32'hAAAA_AAAA;
            8:       return 32'h0000_002A;
            9:       return 32'h1234_5678;
            10:      return 32'hFFFF_FFFE;
            default: return 32'h0000_0007;
        endcase
    endfunction

    // Offer one command beat and hold it until the block takes it. Entered and
    // left at a falling edge; valid stays high when no gap follows.
    task automatic send_cmd(input logic [2:0] c, input logic [bvl_pkg::DATA_W-1:0] v);
        int gap;
        gap = sender_idles ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd   <= c;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.take_command(c, v);
        if (c <= bvl_pkg::CMD_CONTAINS) begin
            items_sent++;
        end
        @(negedge aclk);
    endtask

    // Mixed commands with a lean toward growth so the list gets long.
    task automatic run_mixed();
        int          n;
        int          r;
        logic [2:0]  c;
        n = $urandom_range(20, 80);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 38) begin
                c = bvl_pkg::CMD_APPEND;
            end else if (r < 56) begin
                c = bvl_pkg::CMD_PREPEND;
            end else if (r < 74) begin
                c = bvl_pkg::CMD_REMOVE;
            end else if (r < 94) begin
                c = bvl_pkg::CMD_CONTAINS;
            end else if (r < 96) begin
                c = bvl_pkg::CMD_CLEAR;
            end else begin
                c = bvl_pkg::CMD_CONTAINS + 3'($urandom_range(1, 3));
            end
            send_cmd(c, pick_value());
        end
    endtask

    // Fill the list to capacity, push against the limit, search the full list.
    task automatic run_fill();
        while (sb.fill < bvl_pkg::CAPACITY) begin
            send_cmd($urandom_range(0, 2) != 0 ? bvl_pkg::CMD_APPEND
                                               : bvl_pkg::CMD_PREPEND, pick_value());
        end
        repeat ($urandom_range(3, 6)) begin
            send_cmd($urandom_range(0, 1) ? bvl_pkg::CMD_APPEND : bvl_pkg::CMD_PREPEND,
                     pick_value());
        end
        repeat ($urandom_range(2, 5)) begin
            send_cmd($urandom_range(0, 1) ? bvl_pkg::CMD_REMOVE : bvl_pkg::CMD_CONTAINS,
                     pick_value());
        end
        if ($urandom_range(0, 1)) begin
            send_cmd(bvl_pkg::CMD_CLEAR, $urandom);
        end
    endtask

    // Remove or look up values known to be stored, at random positions.
    task automatic run_drain();
        int          n;
        int unsigned pos;
        n = $urandom_range(10, 40);
        repeat (n) begin
            if (sb.fill > 0) begin
                pos = $urandom_range(0, sb.fill - 1);
                send_cmd($urandom_range(0, 9) < 7 ? bvl_pkg::CMD_REMOVE
                                                  : bvl_pkg::CMD_CONTAINS,
                         sb.value_at(pos));
            end
        end
    endtask

    // Main stimulus: reset, directed commands, then random episodes.
    initial begin
        int start;
        int r;
        bit first;
        sb            = new();
        items_sent    = 0;
        sender_idles  = 1'b1;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_cmd         <= bvl_pkg::CMD_CLEAR;
        s_value       <= '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Searches on an empty list, extremes of the value range, duplicates,
        // removal at head and tail, unused command codes, stale entries after
        // clear, and a prepend that wraps the head below slot zero.
        send_cmd(bvl_pkg::CMD_CONTAINS, 32'h0000_0000);
        send_cmd(bvl_pkg::CMD_REMOVE,   32'h0000_0005);
        send_cmd(bvl_pkg::CMD_APPEND,   32'h7FFF_FFFF);
        send_cmd(bvl_pkg::CMD_APPEND,   32'h8000_0000);
        send_cmd(bvl_pkg::CMD_PREPEND,  32'h0000_0000);
        send_cmd(bvl_pkg::CMD_PREPEND,  32'hFFFF_FFFF);
        send_cmd(bvl_pkg::CMD_APPEND,   32'h8000_0000);
        send_cmd(bvl_pkg::CMD_CONTAINS, 32'h8000_0000);
        send_cmd(bvl_pkg::CMD_CONTAINS, 32'h1234_5678);
        send_cmd(bvl_pkg::CMD_REMOVE,   32'h8000_0000);
        send_cmd(bvl_pkg::CMD_CONTAINS, 32'h8000_0000);
        send_cmd(bvl_pkg::CMD_REMOVE,   32'hFFFF_FFFF);
        send_cmd(bvl_pkg::CMD_REMOVE,   32'h8000_0000);
        send_cmd(bvl_pkg::CMD_REMOVE,   32'h7FFF_FFFF);
        send_cmd(bvl_pkg::CMD_CONTAINS + 3'd1, 32'hFFFF_FFFF);
        send_cmd(bvl_pkg::CMD_CONTAINS + 3'd2, 32'h0000_0000);
        send_cmd(bvl_pkg::CMD_CONTAINS + 3'd3, 32'h5555_5555);
        send_cmd(bvl_pkg::CMD_REMOVE,   32'h5555_5555);
        send_cmd(bvl_pkg::CMD_CLEAR,    32'hFFFF_FFFF);
        send_cmd(bvl_pkg::CMD_CONTAINS, 32'h0000_0000);
        send_cmd(bvl_pkg::CMD_PREPEND,  32'hAAAA_AAAA);
        send_cmd(bvl_pkg::CMD_APPEND,   32'h5555_5555);
        send_cmd(bvl_pkg::CMD_REMOVE,   32'hAAAA_AAAA);
        send_cmd(bvl_pkg::CMD_CLEAR,    32'h0000_0000);

        // Random episodes; the first one always fills the list.
        start = items_sent;
        first = 1'b1;
        while (items_sent - start < RANDOM_ITEMS) begin
            sender_idles = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (first || r < 10) begin
                run_fill();
            end else if (r < 25) begin
                run_drain();
            end else begin
                run_mixed();
            end
            first = 1'b0;
        end
        s_valid <= 1'b0;

        // Let the last results drain, then watch for stray beats.
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Result side: random stalls in changing modes, plus one long hold-off that
    // backs the block up until it stops taking commands.
    initial begin
        int hold;
        int span;
        bit idles;
        m_ready       <= 1'b0;
        pressure_done = 1'b0;
        hold          = 0;
        @(posedge aresetn);
        forever begin
            idles = ($urandom_range(0, 3) != 0);
            span  = $urandom_range(100, 400);
            repeat (span) begin
                @(negedge aclk);
                if (!pressure_done && sb.accepted >= PRESSURE_AT) begin
                    m_ready <= 1'b0;
                    repeat (PRESSURE_LEN) @(negedge aclk);
                    pressure_done = 1'b1;
                    hold          = 0;
                end else if (hold > 0) begin
                    m_ready <= 1'b0;
                    hold--;
                end else begin
                    m_ready <= 1'b1;
                    if (idles) begin
                        hold = pick_gap();
                    end
                end
            end
        end
    end

    // Check every result beat as it is taken.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_status, m_found, m_count);
        end
    end

    // Hard stop in case the block hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial cycle_count = 0;

endmodule
